// ===== hdl/slid_pkg.sv =====
// shared types and codes for the sorted list insert/delete unit
`timescale 1ns / 1ps
package slid_pkg;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// input beat
	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] key_value;
	} in_t;

	// result beat
	typedef struct packed {
		logic signed [31:0] entry_value;
		logic [1:0]         status;
		logic               last;
	} out_t;

	// classified operation held in the queue
	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] key;
	} op_t;

	// queue fill status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hdl/sorted_list_insert_delete_unit.sv =====
// top level of the sorted list insert/delete unit
//
//  channel   | handshake      | payload          | beat taken when
//  ----------+----------------+------------------+--------------------------
//  command   | start / busy   | item   (in_t)    | start high and busy low
//  result    | strobe         | result (out_t)   | every cycle strobe is high
//
// inserts and deletes update the cell row; one goes in per cycle while busy is low.
// a read-out holds the cell row while it gives one result beat per stored entry.
// a command passes the front stage, the op queue and the result register in turn.
// busy rises only while a read-out holds the cell row and the op queue has filled.
// arst_n clears the count, queue and sequencer; there is no clearing pass.
// results cannot be stalled: each beat is shown for one cycle only.
`timescale 1ns / 1ps
module sorted_list_insert_delete_unit import slid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic strobe,
	output out_t result
);

	q_stat_t q_stat;
	logic    push;
	op_t     push_op;
	logic    pop;
	op_t     pop_op;

	// accept and classify
	slid_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_stat  (q_stat),
		.push    (push),
		.push_op (push_op)
	);

	// decoupling queue
	slid_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.q_stat  (q_stat)
	);

	// cell row and read-out
	slid_cells #(
		.CAPACITY (CAPACITY)
	) u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.pop_op (pop_op),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

// ===== hdl/slid_front.sv =====
// front end: accepts input beats, drops unused commands, feeds the queue
`timescale 1ns / 1ps
module slid_front import slid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  in_t     item,
	input  q_stat_t q_stat,
	output logic    push,
	output op_t     push_op
);

	logic valid_s1;
	op_t  op_s1;
	logic accept;
	logic cmd_known;

	// hand the held op over whenever the queue has room
	assign push    = valid_s1 && !q_stat.full;
	assign push_op = op_s1;
	assign busy    = valid_s1 && q_stat.full;
	assign accept  = start && !busy;

	// classify: only insert, delete and read-out go on
	assign cmd_known = (item.cmd == CMD_INSERT) || (item.cmd == CMD_DELETE) ||
		(item.cmd == CMD_READ);

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= cmd_known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1.cmd <= item.cmd;
			op_s1.key <= item.key_value;
		end
	end

endmodule

// ===== hdl/slid_queue.sv =====
// short op queue between front end and cell array
`timescale 1ns / 1ps
module slid_queue import slid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  op_t     push_op,
	input  logic    pop,
	output op_t     pop_op,
	output q_stat_t q_stat
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	op_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;

	assign pop_op       = mem_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == FW'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/slid_cells.sv =====
// back end: row of compare-and-shift cells plus read-out sequencer
`timescale 1ns / 1ps
module slid_cells import slid_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  op_t     pop_op,
	output logic    pop,
	output logic    strobe,
	output out_t    result
);

	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic signed [31:0] entry_q [CAPACITY];
	logic [CW-1:0]      count_q;
	logic               state_q;
	logic [CW-1:0]      rd_idx_q;
	logic               strobe_q;
	out_t               result_q;

	logic [CAPACITY-1:0] in_use;
	logic [CAPACITY-1:0] le;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] ge;
	logic signed [31:0]  prev_w [CAPACITY];
	logic signed [31:0]  next_w [CAPACITY];
	logic                found;
	logic                is_full;
	logic                is_empty;
	logic [CW-1:0]       last_idx;
	logic                rd_last;
	logic                do_ins;
	logic                do_del;
	logic                do_rot;
	logic                strobe_d;
	out_t                result_d;

	assign pop      = (state_q == S_IDLE) && !q_stat.empty;
	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign last_idx = count_q - 1'b1;
	assign rd_last  = (rd_idx_q == last_idx);
	assign found    = |eq;

	assign do_ins = pop && (pop_op.cmd == CMD_INSERT) && !is_full;
	assign do_del = pop && (pop_op.cmd == CMD_DELETE) && found;
	assign do_rot = (state_q == S_READ);

	// per-cell compare flags and neighbor taps
	for (genvar i = 0; i < CAPACITY; i++) begin : g_flag
		assign in_use[i] = (CW'(i) < count_q);
		assign le[i]     = in_use[i] && (entry_q[i] <= pop_op.key);
		assign eq[i]     = in_use[i] && (entry_q[i] == pop_op.key);
		assign ge[i]     = (entry_q[i] >= pop_op.key);
		if (i == 0) begin : g_first
			assign prev_w[i] = pop_op.key;
		end else begin : g_mid
			// a new key lands right after the last entry not above it
			assign prev_w[i] = le[i-1] ? pop_op.key : entry_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_top
			assign next_w[i] = entry_q[i];
		end else begin : g_low
			assign next_w[i] = entry_q[i+1];
		end
	end

	// cell update: insert shifts up, delete closes the gap, read-out rotates
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (!le[i]) begin
					entry_q[i] <= prev_w[i];
				end
			end else if (do_del) begin
				if (ge[i]) begin
					entry_q[i] <= next_w[i];
				end
			end else if (do_rot) begin
				if (CW'(i) == last_idx) begin
					entry_q[i] <= entry_q[0];
				end else if (CW'(i) < last_idx) begin
					entry_q[i] <= next_w[i];
				end
			end
		end
	end

	// result for the current op or read-out step
	always_comb begin
		strobe_d = 1'b0;
		result_d = '{entry_value: pop_op.key, status: ST_OK, last: 1'b1};
		if (do_rot) begin
			strobe_d = 1'b1;
			result_d = '{entry_value: entry_q[0], status: ST_OK, last: rd_last};
		end else if (pop) begin
			case (pop_op.cmd)
				CMD_INSERT: begin
					strobe_d = 1'b1;
					result_d.status = is_full ? ST_FULL : ST_OK;
				end
				CMD_DELETE: begin
					strobe_d = 1'b1;
					if (is_empty) begin
						result_d.status = ST_EMPTY;
					end else if (!found) begin
						result_d.status = ST_NOTFOUND;
					end
				end
				CMD_READ: begin
					if (is_empty) begin
						strobe_d = 1'b1;
						result_d = '{entry_value: '0, status: ST_EMPTY, last: 1'b1};
					end
				end
				default: begin
					strobe_d = 1'b0;
				end
			endcase
		end
	end

	// count, sequencer and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			state_q  <= S_IDLE;
			rd_idx_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_del) begin
				count_q <= count_q - 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && (pop_op.cmd == CMD_READ) && !is_empty) begin
						state_q  <= S_READ;
						rd_idx_q <= '0;
					end
				end
				S_READ: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (strobe_d) begin
			result_q <= result_d;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== hdl/slid_checker.sv =====
// port-level checks for the sorted list unit and their bind
`timescale 1ns / 1ps
module slid_checker import slid_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic strobe,
	input out_t result
);

	// a read-out beat that is not the last is followed at once by the next
	property p_readout_runs;
		@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe;
	endproperty
	a_readout_runs: assert property (p_readout_runs)
		else $error("read-out stream broke before its last beat");

	// any error status closes its command
	property p_error_is_last;
		@(posedge clk) disable iff (!arst_n)
		strobe && (result.status != ST_OK) |-> result.last;
	endproperty
	a_error_is_last: assert property (p_error_is_last)
		else $error("error status on a beat that is not last");

	// read-out comes in ascending order
	property p_ascending;
		@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=>
			($signed(result.entry_value) >= $signed($past(result.entry_value)));
	endproperty
	a_ascending: assert property (p_ascending)
		else $error("read-out beats out of order");

	// nothing comes out and nothing is held off in the first cycles after reset
	property p_quiet_after_reset;
		@(posedge clk)
		$rose(arst_n) |-> (!strobe && !busy) ##1 !strobe;
	endproperty
	a_quiet_after_reset: assert property (p_quiet_after_reset)
		else $error("result beat or busy right after reset");

endmodule

bind sorted_list_insert_delete_unit slid_checker u_slid_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
